/* rtl/core/bpet_pkg.sv */
`default_nettype none

package bpet_pkg;

   localparam int ID_W            = 32;
   localparam int OP_W            = 3;
   localparam int COUNT_W         = 7;
   localparam int TABLE_DEPTH_DEF = 64;

   // Cells are grouped by eight for the removal recount.
   localparam int GRP_SIZE = 8;
   localparam int GCNT_W   = 4;

   typedef enum logic [OP_W-1:0] {
      OP_ADD_PAIR    = 3'd0,
      OP_REMOVE_PAIR = 3'd1,
      OP_TEST_PAIR   = 3'd2,
      OP_REMOVE_BODY = 3'd3,
      OP_CLEAR       = 3'd4,
      OP_TEST_BODY   = 3'd5,
      OP_LIST        = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_APPLY,
      ST_RECOUNT,
      ST_LIST
   } state_type;

   // Broadcast controls from the sequencer to every cell of the ring.
   typedef struct packed {
      logic match_en;
      logic rotate;
      logic write_en;
      logic kill_pair;
      logic kill_body;
      logic clear_all;
   } cell_ctl_type;

endpackage : bpet_pkg

`default_nettype wire

/* rtl/core/bpet_if.sv */
`default_nettype none

interface bpet_req_if;
   logic                     valid;
   logic                     ready;
   logic [bpet_pkg::OP_W-1:0] operation;
   logic [bpet_pkg::ID_W-1:0] body_a;
   logic [bpet_pkg::ID_W-1:0] body_b;

   modport source (output valid, output operation, output body_a, output body_b,
                   input ready);
   modport sink   (input valid, input operation, input body_a, input body_b,
                   output ready);
endinterface : bpet_req_if

interface bpet_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        pair_ignored;
   logic                        body_involved;
   logic [bpet_pkg::COUNT_W-1:0] pair_count;
   logic                        any_pairs;
   logic                        table_full_error;
   logic [bpet_pkg::ID_W-1:0]    list_low_id;
   logic [bpet_pkg::ID_W-1:0]    list_high_id;
   logic                        list_valid;
   logic                        last;

   modport source (output valid, output pair_ignored, output body_involved,
                   output pair_count, output any_pairs, output table_full_error,
                   output list_low_id, output list_high_id, output list_valid,
                   output last, input ready);
   modport sink   (input valid, input pair_ignored, input body_involved,
                   input pair_count, input any_pairs, input table_full_error,
                   input list_low_id, input list_high_id, input list_valid,
                   input last, output ready);
endinterface : bpet_rsp_if

`default_nettype wire

/* rtl/core/bpet_cell.sv */
`default_nettype none

// One table entry. It compares itself against the broadcast key, and during
// a listing pass it takes the entry of its upper neighbor.
module bpet_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire bpet_pkg::cell_ctl_type       ctl,
   input  wire logic                         write_sel,
   input  wire logic [bpet_pkg::ID_W-1:0]    key_lo,
   input  wire logic [bpet_pkg::ID_W-1:0]    key_hi,
   input  wire logic [bpet_pkg::ID_W-1:0]    body,
   input  wire logic                         nb_valid,
   input  wire logic [bpet_pkg::ID_W-1:0]    nb_lo,
   input  wire logic [bpet_pkg::ID_W-1:0]    nb_hi,
   output      logic                         entry_valid,
   output      logic [bpet_pkg::ID_W-1:0]    entry_lo,
   output      logic [bpet_pkg::ID_W-1:0]    entry_hi,
   output      logic                         pair_hit,
   output      logic                         body_hit
);

   logic                      valid_ff, valid_in;
   logic [bpet_pkg::ID_W-1:0] lo_ff, lo_in;
   logic [bpet_pkg::ID_W-1:0] hi_ff, hi_in;
   logic                      pair_hit_ff, pair_hit_in;
   logic                      body_hit_ff, body_hit_in;

   always_comb begin
      valid_in    = valid_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      pair_hit_in = pair_hit_ff;
      body_hit_in = body_hit_ff;
      if (ctl.match_en) begin
         pair_hit_in = valid_ff && (lo_ff == key_lo) && (hi_ff == key_hi);
         body_hit_in = valid_ff && ((lo_ff == body) || (hi_ff == body));
      end
      priority if (ctl.clear_all) begin
         valid_in = 1'b0;
      end else if (ctl.rotate) begin
         valid_in = nb_valid;
         lo_in    = nb_lo;
         hi_in    = nb_hi;
      end else if (ctl.write_en && write_sel) begin
         valid_in = 1'b1;
         lo_in    = key_lo;
         hi_in    = key_hi;
      end else if ((ctl.kill_pair && pair_hit_ff) || (ctl.kill_body && body_hit_ff)) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         pair_hit_ff <= 1'b0;
         body_hit_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         pair_hit_ff <= pair_hit_in;
         body_hit_ff <= body_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   assign entry_valid = valid_ff;
   assign entry_lo    = lo_ff;
   assign entry_hi    = hi_ff;
   assign pair_hit    = pair_hit_ff;
   assign body_hit    = body_hit_ff;

endmodule : bpet_cell

`default_nettype wire

/* rtl/core/body_pair_exclusion_table_unit.sv */
`default_nettype none

// Channel | Direction | Payload                                   | Handshake
// req_bus | in        | operation, body_a, body_b                 | valid/ready
// rsp_bus | out       | status, count, listed pair, list_valid, last | valid/ready
//
// The accepting edge captures the transaction with its pair normalized. In
// ST_MATCH every cell registers its comparison; in ST_APPLY, once the result
// register is free, the ring is updated, the result is registered and the
// request side is ready again. Removing a body adds the ST_RECOUNT state for
// the recount. A listing then rotates the ring once. Reset is synchronous and
// clears every valid bit and the pair count; the id storage needs no clearing.
// A stalled result holds the sequencer in ST_APPLY and ST_RECOUNT, and in
// ST_LIST while cell 0 shows a stored pair.
module body_pair_exclusion_table_unit #(
   parameter int TABLE_DEPTH = bpet_pkg::TABLE_DEPTH_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   bpet_req_if.sink   req_bus,
   bpet_rsp_if.source rsp_bus
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int NGRP  = (TABLE_DEPTH + bpet_pkg::GRP_SIZE - 1) / bpet_pkg::GRP_SIZE;

   // Sequencer state and the captured transaction.
   bpet_pkg::state_type       state_ff, state_in;
   logic [bpet_pkg::OP_W-1:0] op_ff;
   logic [bpet_pkg::ID_W-1:0] key_lo_ff, key_hi_ff, body_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          emit_ff, emit_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [bpet_pkg::GCNT_W-1:0] grp_ff [NGRP];
   logic [bpet_pkg::GCNT_W-1:0] grp_in [NGRP];

   // Result register.
   logic                         rsp_valid_ff;
   logic                         ign_ff, ign_in;
   logic                         inv_ff, inv_in;
   logic [bpet_pkg::COUNT_W-1:0] cnt_out_ff;
   logic                         any_ff;
   logic                         err_ff, err_in;
   logic [bpet_pkg::ID_W-1:0]    list_lo_ff, list_lo_in;
   logic [bpet_pkg::ID_W-1:0]    list_hi_ff, list_hi_in;
   logic                         lv_ff, lv_in;
   logic                         last_ff, last_in;
   logic                         rsp_load;

   // The ring of cells.
   bpet_pkg::cell_ctl_type    ctl;
   logic [TABLE_DEPTH-1:0]    write_sel;
   logic [TABLE_DEPTH-1:0]    valid_v, pair_hit_v, body_hit_v, free_v, first_free;
   logic [bpet_pkg::ID_W-1:0] lo_arr [TABLE_DEPTH];
   logic [bpet_pkg::ID_W-1:0] hi_arr [TABLE_DEPTH];

   logic req_accept, slot_free, any_pair, any_body, any_free;
   logic [CNT_W-1:0] removed;

   genvar gi;
   generate
      for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
         // Cell i takes the entry of cell i+1 on a rotation, so cell 0 presents
         // the entries in ascending entry order during a listing pass.
         bpet_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .write_sel   (write_sel[gi]),
            .key_lo      (key_lo_ff),
            .key_hi      (key_hi_ff),
            .body        (body_ff),
            .nb_valid    (valid_v[(gi + 1) % TABLE_DEPTH]),
            .nb_lo       (lo_arr[(gi + 1) % TABLE_DEPTH]),
            .nb_hi       (hi_arr[(gi + 1) % TABLE_DEPTH]),
            .entry_valid (valid_v[gi]),
            .entry_lo    (lo_arr[gi]),
            .entry_hi    (hi_arr[gi]),
            .pair_hit    (pair_hit_v[gi]),
            .body_hit    (body_hit_v[gi])
         );
      end
   endgenerate

   assign req_bus.ready = (state_ff == bpet_pkg::ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;

   // Lowest free entry, isolated as the lowest set bit of the free mask.
   assign free_v     = ~valid_v;
   assign first_free = free_v & (~free_v + TABLE_DEPTH'(1));
   assign any_free   = |free_v;
   assign any_pair   = |pair_hit_v;
   assign any_body   = |body_hit_v;

   // Per-group counts of the entries a body removal drops.
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < bpet_pkg::GRP_SIZE; k++) begin
            if (g * bpet_pkg::GRP_SIZE + k < TABLE_DEPTH) begin
               grp_in[g] = grp_in[g]
                         + bpet_pkg::GCNT_W'(body_hit_v[g * bpet_pkg::GRP_SIZE + k]);
            end
         end
      end
   end

   always_comb begin
      removed = '0;
      for (int g = 0; g < NGRP; g++) begin
         removed = removed + CNT_W'(grp_ff[g]);
      end
   end

   // Sequencer: next state, cell controls and the result to register.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      emit_in    = emit_ff;
      idx_in     = idx_ff;
      ctl        = '0;
      write_sel  = '0;
      rsp_load   = 1'b0;
      ign_in     = 1'b0;
      inv_in     = 1'b0;
      err_in     = 1'b0;
      list_lo_in = '0;
      list_hi_in = '0;
      lv_in      = 1'b0;
      last_in    = 1'b1;

      unique case (state_ff)
         bpet_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = bpet_pkg::ST_MATCH;
            end
         end

         bpet_pkg::ST_MATCH: begin
            ctl.match_en = 1'b1;
            state_in     = bpet_pkg::ST_APPLY;
         end

         bpet_pkg::ST_APPLY: begin
            if (slot_free) begin
               state_in = bpet_pkg::ST_IDLE;
               rsp_load = 1'b1;
               case (bpet_pkg::op_type'(op_ff))
                  bpet_pkg::OP_ADD_PAIR: begin
                     // A stored pair is left alone; a new one needs a free entry.
                     if (!any_pair) begin
                        if (any_free) begin
                           ctl.write_en = 1'b1;
                           write_sel    = first_free;
                           count_in     = count_ff + CNT_W'(1);
                        end else begin
                           err_in = 1'b1;
                        end
                     end
                  end
                  bpet_pkg::OP_REMOVE_PAIR: begin
                     ctl.kill_pair = 1'b1;
                     if (any_pair) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  bpet_pkg::OP_TEST_PAIR: begin
                     ign_in = any_pair;
                  end
                  bpet_pkg::OP_REMOVE_BODY: begin
                     // The count is settled in ST_RECOUNT from the registered group counts.
                     ctl.kill_body = 1'b1;
                     rsp_load      = 1'b0;
                     state_in      = bpet_pkg::ST_RECOUNT;
                  end
                  bpet_pkg::OP_CLEAR: begin
                     ctl.clear_all = 1'b1;
                     count_in      = '0;
                  end
                  bpet_pkg::OP_TEST_BODY: begin
                     inv_in = any_body;
                  end
                  bpet_pkg::OP_LIST: begin
                     // An empty table answers with one result that lists nothing.
                     if (count_ff != '0) begin
                        rsp_load = 1'b0;
                        emit_in  = '0;
                        idx_in   = '0;
                        state_in = bpet_pkg::ST_LIST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         bpet_pkg::ST_RECOUNT: begin
            if (slot_free) begin
               count_in = count_ff - removed;
               rsp_load = 1'b1;
               state_in = bpet_pkg::ST_IDLE;
            end
         end

         bpet_pkg::ST_LIST: begin
            // The ring turns once; cell 0 shows each entry in turn. A stored
            // pair moves on only once the result register can take it.
            if (!valid_v[0] || slot_free) begin
               ctl.rotate = 1'b1;
               if (valid_v[0]) begin
                  rsp_load   = 1'b1;
                  list_lo_in = lo_arr[0];
                  list_hi_in = hi_arr[0];
                  lv_in      = 1'b1;
                  last_in    = (emit_ff + CNT_W'(1)) == count_ff;
                  emit_in    = emit_ff + CNT_W'(1);
               end
               if (idx_ff == IDX_W'(TABLE_DEPTH - 1)) begin
                  state_in = bpet_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end

         default: begin
            state_in = bpet_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpet_pkg::ST_IDLE;
         count_ff     <= '0;
         emit_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         emit_ff  <= emit_in;
         idx_ff   <= idx_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Capture the transaction with the pair normalized, smaller id first.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_bus.operation;
         body_ff <= req_bus.body_a;
         if (req_bus.body_a < req_bus.body_b) begin
            key_lo_ff <= req_bus.body_a;
            key_hi_ff <= req_bus.body_b;
         end else begin
            key_lo_ff <= req_bus.body_b;
            key_hi_ff <= req_bus.body_a;
         end
      end
      if (state_ff == bpet_pkg::ST_APPLY) begin
         grp_ff <= grp_in;
      end
      if (rsp_load) begin
         ign_ff     <= ign_in;
         inv_ff     <= inv_in;
         cnt_out_ff <= bpet_pkg::COUNT_W'(count_in);
         any_ff     <= (count_in != '0);
         err_ff     <= err_in;
         list_lo_ff <= list_lo_in;
         list_hi_ff <= list_hi_in;
         lv_ff      <= lv_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.pair_ignored     = ign_ff;
   assign rsp_bus.body_involved    = inv_ff;
   assign rsp_bus.pair_count       = cnt_out_ff;
   assign rsp_bus.any_pairs        = any_ff;
   assign rsp_bus.table_full_error = err_ff;
   assign rsp_bus.list_low_id      = list_lo_ff;
   assign rsp_bus.list_high_id     = list_hi_ff;
   assign rsp_bus.list_valid       = lv_ff;
   assign rsp_bus.last             = last_ff;

   // The pair count never exceeds the table size.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("pair count beyond table depth");

   // Pairs are stored once, so a pair lookup hits at most one cell.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpet_pkg::ST_APPLY) |-> $onehot0(pair_hit_v))
      else $error("pair stored in more than one cell");

   // Between transactions the count agrees with the valid cells.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpet_pkg::ST_IDLE) |-> (int'(count_ff) == $countones(valid_v)))
      else $error("pair count disagrees with valid cells");

endmodule : body_pair_exclusion_table_unit

`default_nettype wire

/* bench/body_pair_exclusion_table_unit_test.sv */
`timescale 1ns / 100ps

module body_pair_exclusion_table_unit_test;

   localparam int ID_W    = bpet_pkg::ID_W;
   localparam int OP_W    = bpet_pkg::OP_W;
   localparam int COUNT_W = bpet_pkg::COUNT_W;
   localparam int DEPTH   = bpet_pkg::TABLE_DEPTH_DEF;
   // The block defines no behavior for this code except a plain status transaction.
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
   // Watchdog limit for the whole run, in cycles.
   localparam int CYCLE_LIMIT = 200_000;
   // A listing can take a full ring rotation, so the quiet tail covers that.
   localparam int TAIL_CYCLES = 2 * DEPTH + 16;

   // One result transaction, in the same field order as the result channel.
   typedef struct packed {
      logic               pair_ignored;
      logic               body_involved;
      logic [COUNT_W-1:0] pair_count;
      logic               any_pairs;
      logic               table_full_error;
      logic [ID_W-1:0]    list_low_id;
      logic [ID_W-1:0]    list_high_id;
      logic               list_valid;
      logic               last;
   } table_reply_type;

   logic clock;
   logic reset;

   bpet_req_if req_bus ();
   bpet_rsp_if rsp_bus ();

   body_pair_exclusion_table_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   // Shadow copy of the pair table. Entries are kept in normalized form,
   // smaller id first, and a new pair takes the lowest free entry.
   logic            shadow_valid [DEPTH];
   logic [ID_W-1:0] shadow_low   [DEPTH];
   logic [ID_W-1:0] shadow_high  [DEPTH];
   int              shadow_count;

   // Replies that the block still owes us, oldest first.
   table_reply_type replies_due [$];

   int  mismatch_count;
   int  cycle_count;
   int  items_sent;
   int  replies_checked;
   int  listed_pairs_seen;
   int  full_errors_seen;
   // While set, neither the sender nor the receiver ever idles.
   logic steady_phase;

   // Ids used by the random test, so that pairs and bodies collide often.
   logic [ID_W-1:0] id_pool [10];

   always #1 clock = ~clock;

   // Outside the steady phase the receiver stalls with a chance of seven in a
   // hundred, changing its ready only on the falling edge.
   always @(negedge clock) begin
      rsp_bus.ready <= steady_phase || ($urandom_range(99) >= 7);
   end

   // Global watchdog: a hung handshake or a missing result ends up here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Builds a status transaction from the shadow count; list fields are zero.
   function automatic table_reply_type status_reply(logic ign, logic inv, logic err);
      table_reply_type r;
      r                  = '0;
      r.pair_ignored     = ign;
      r.body_involved    = inv;
      r.pair_count       = COUNT_W'(shadow_count);
      r.any_pairs        = (shadow_count != 0);
      r.table_full_error = err;
      r.last             = 1'b1;
      return r;
   endfunction

   // Applies one accepted request to the shadow table and queues the replies
   // that it must produce.
   function automatic void shadow_apply(logic [OP_W-1:0] op, logic [ID_W-1:0] a,
                                        logic [ID_W-1:0] b);
      logic [ID_W-1:0] lo;
      logic [ID_W-1:0] hi;
      logic            ign;
      logic            inv;
      logic            err;
      int              hit;
      int              free_slot;
      int              n;
      table_reply_type r;
      lo  = (a < b) ? a : b;
      hi  = (a < b) ? b : a;
      ign = 1'b0;
      inv = 1'b0;
      err = 1'b0;
      hit = -1;
      for (int i = 0; i < DEPTH; i++) begin
         if (hit < 0 && shadow_valid[i] && shadow_low[i] == lo && shadow_high[i] == hi) begin
            hit = i;
         end
      end
      case (op)
         bpet_pkg::OP_ADD_PAIR: begin
            // A pair that is already stored is left alone and raises no error.
            if (hit < 0) begin
               free_slot = -1;
               for (int i = 0; i < DEPTH; i++) begin
                  if (free_slot < 0 && !shadow_valid[i]) begin
                     free_slot = i;
                  end
               end
               if (free_slot < 0) begin
                  err = 1'b1;
               end else begin
                  shadow_valid[free_slot] = 1'b1;
                  shadow_low[free_slot]   = lo;
                  shadow_high[free_slot]  = hi;
                  shadow_count++;
               end
            end
         end
         bpet_pkg::OP_REMOVE_PAIR: begin
            if (hit >= 0) begin
               shadow_valid[hit] = 1'b0;
               shadow_count--;
            end
         end
         bpet_pkg::OP_TEST_PAIR: begin
            ign = (hit >= 0);
         end
         bpet_pkg::OP_REMOVE_BODY: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (shadow_valid[i] && (shadow_low[i] == a || shadow_high[i] == a)) begin
                  shadow_valid[i] = 1'b0;
                  shadow_count--;
               end
            end
         end
         bpet_pkg::OP_CLEAR: begin
            for (int i = 0; i < DEPTH; i++) begin
               shadow_valid[i] = 1'b0;
            end
            shadow_count = 0;
         end
         bpet_pkg::OP_TEST_BODY: begin
            // Involvement is derived from the stored pairs alone.
            for (int i = 0; i < DEPTH; i++) begin
               if (shadow_valid[i] && (shadow_low[i] == a || shadow_high[i] == a)) begin
                  inv = 1'b1;
               end
            end
         end
         bpet_pkg::OP_LIST: begin
            // One transaction per stored pair in entry order; the final one
            // carries last. An empty table gives one transaction, not valid.
            n = 0;
            for (int i = 0; i < DEPTH; i++) begin
               if (shadow_valid[i]) begin
                  r              = status_reply(1'b0, 1'b0, 1'b0);
                  r.list_low_id  = shadow_low[i];
                  r.list_high_id = shadow_high[i];
                  r.list_valid   = 1'b1;
                  r.last         = 1'b0;
                  replies_due    = {replies_due, r};
                  n++;
               end
            end
            if (n == 0) begin
               replies_due = {replies_due, status_reply(1'b0, 1'b0, 1'b0)};
            end else begin
               replies_due[replies_due.size() - 1].last = 1'b1;
            end
            return;
         end
         default: begin
         end
      endcase
      replies_due = {replies_due, status_reply(ign, inv, err)};
   endfunction

   task automatic check_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Every accepted result is compared against the oldest reply still owed.
   always @(posedge clock) begin : reply_checker
      table_reply_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (replies_due.size() == 0) begin
            $error("result transaction arrived with no reply outstanding");
            mismatch_count++;
         end else begin
            want = replies_due.pop_front();
            check_field("pair_ignored", ID_W'(want.pair_ignored),
                        ID_W'(rsp_bus.pair_ignored));
            check_field("body_involved", ID_W'(want.body_involved),
                        ID_W'(rsp_bus.body_involved));
            check_field("pair_count", ID_W'(want.pair_count), ID_W'(rsp_bus.pair_count));
            check_field("any_pairs", ID_W'(want.any_pairs), ID_W'(rsp_bus.any_pairs));
            check_field("table_full_error", ID_W'(want.table_full_error),
                        ID_W'(rsp_bus.table_full_error));
            check_field("list_low_id", want.list_low_id, rsp_bus.list_low_id);
            check_field("list_high_id", want.list_high_id, rsp_bus.list_high_id);
            check_field("list_valid", ID_W'(want.list_valid), ID_W'(rsp_bus.list_valid));
            check_field("last", ID_W'(want.last), ID_W'(rsp_bus.last));
            if (want.list_valid) listed_pairs_seen++;
            if (want.table_full_error) full_errors_seen++;
         end
         replies_checked++;
      end
   end

   // Presents one request on the falling edge, possibly after idle cycles drawn
   // at random, and holds it until the block takes it. The shadow table is
   // updated on the very edge that accepts the transaction.
   task automatic send_op(logic [OP_W-1:0] op, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
      while (!steady_phase && $urandom_range(99) < 7) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.operation = op;
      req_bus.body_a    = a;
      req_bus.body_b    = b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      shadow_apply(op, a, b);
      items_sent++;
      @(negedge clock);
   endtask

   // Holds the request side quiet until every owed reply has come back.
   task automatic wait_for_drain();
      req_bus.valid = 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
   endtask

   // Extremes of the ids, every operation, duplicates, equal ids, absent
   // removals, reversed order, body removal and the empty listing.
   task automatic test_directed_ops();
      send_op(bpet_pkg::OP_LIST, '0, '0);
      send_op(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(bpet_pkg::OP_TEST_BODY, '0, 32'hFFFF_FFFF);
      send_op(bpet_pkg::OP_ADD_PAIR, 32'hFFFF_FFFF, '0);
      send_op(bpet_pkg::OP_ADD_PAIR, '0, 32'hFFFF_FFFF);
      send_op(bpet_pkg::OP_ADD_PAIR, 32'd7, 32'd7);
      send_op(bpet_pkg::OP_ADD_PAIR, 32'h8000_0000, 32'h7FFF_FFFF);
      send_op(bpet_pkg::OP_TEST_PAIR, '0, 32'hFFFF_FFFF);
      send_op(bpet_pkg::OP_TEST_PAIR, 32'hFFFF_FFFF, '0);
      send_op(bpet_pkg::OP_TEST_PAIR, 32'd7, 32'd8);
      send_op(bpet_pkg::OP_TEST_BODY, 32'd7, '0);
      send_op(bpet_pkg::OP_TEST_BODY, 32'hFFFF_FFFF, $urandom);
      send_op(bpet_pkg::OP_TEST_BODY, 32'd1, 32'd7);
      send_op(bpet_pkg::OP_LIST, $urandom, $urandom);
      send_op(bpet_pkg::OP_REMOVE_PAIR, 32'hFFFF_FFFF, '0);
      send_op(bpet_pkg::OP_REMOVE_PAIR, 32'd1, 32'd2);
      send_op(bpet_pkg::OP_REMOVE_BODY, 32'd99, 32'd7);
      send_op(bpet_pkg::OP_ADD_PAIR, 32'd9, 32'd7);
      // Both pairs holding body 7 go; body 9 must then read as not involved.
      send_op(bpet_pkg::OP_REMOVE_BODY, 32'd7, $urandom);
      send_op(bpet_pkg::OP_TEST_BODY, 32'd9, '0);
      send_op(OP_UNUSED, $urandom, $urandom);
      send_op(bpet_pkg::OP_LIST, '0, '0);
      send_op(bpet_pkg::OP_CLEAR, $urandom, $urandom);
      send_op(bpet_pkg::OP_LIST, '0, '0);
   endtask

   // Fills every entry without any idling, then checks the overflow error, a
   // duplicate add into a full table, lowest-free-entry reuse and a full-length
   // listing.
   task automatic test_full_table();
      steady_phase = 1'b1;
      for (int k = 0; k < DEPTH; k++) begin
         send_op(bpet_pkg::OP_ADD_PAIR, $urandom, 32'(k));
      end
      steady_phase = 1'b0;
      send_op(bpet_pkg::OP_ADD_PAIR, 32'hDEAD_0001, 32'hDEAD_0002);
      send_op(bpet_pkg::OP_ADD_PAIR, 32'd3,
              shadow_low[3] == 32'd3 ? shadow_high[3] : shadow_low[3]);
      send_op(bpet_pkg::OP_TEST_PAIR, shadow_high[10], shadow_low[10]);
      send_op(bpet_pkg::OP_LIST, '0, '0);
      send_op(bpet_pkg::OP_REMOVE_PAIR, shadow_low[5], shadow_high[5]);
      send_op(bpet_pkg::OP_REMOVE_BODY, 32'd20, '0);
      send_op(bpet_pkg::OP_ADD_PAIR, 32'hDEAD_0001, 32'hDEAD_0002);
      send_op(bpet_pkg::OP_ADD_PAIR, 32'hDEAD_0003, 32'hDEAD_0003);
      send_op(bpet_pkg::OP_ADD_PAIR, 32'hDEAD_0004, 32'hDEAD_0005);
      send_op(bpet_pkg::OP_LIST, '0, '0);
      send_op(bpet_pkg::OP_CLEAR, '0, '0);
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(99) < 85) return id_pool[$urandom_range(9)];
      return $urandom;
   endfunction

   // Random mix weighted toward adds and queries over a small id pool, with
   // fully random ids as noise. Part of it runs without any idling, and the
   // sender once holds off until all replies are back.
   task automatic test_random_traffic(int count);
      int sel;
      id_pool[0] = '0;
      id_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 10; i++) id_pool[i] = $urandom;
      for (int n = 0; n < count; n++) begin
         steady_phase = (n >= 4 && n < 16);
         if (n == 10) wait_for_drain();
         sel = $urandom_range(99);
         if (sel < 36)      send_op(bpet_pkg::OP_ADD_PAIR, pick_id(), pick_id());
         else if (sel < 48) send_op(bpet_pkg::OP_REMOVE_PAIR, pick_id(), pick_id());
         else if (sel < 64) send_op(bpet_pkg::OP_TEST_PAIR, pick_id(), pick_id());
         else if (sel < 71) send_op(bpet_pkg::OP_REMOVE_BODY, pick_id(), $urandom);
         else if (sel < 87) send_op(bpet_pkg::OP_TEST_BODY, pick_id(), $urandom);
         else if (sel < 94) send_op(bpet_pkg::OP_LIST, $urandom, $urandom);
         else if (sel < 97) send_op(bpet_pkg::OP_CLEAR, $urandom, $urandom);
         else               send_op(OP_UNUSED, $urandom, $urandom);
      end
      steady_phase = 1'b0;
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = '0;
      req_bus.body_a    = '0;
      req_bus.body_b    = '0;
      rsp_bus.ready     = 1'b0;
      steady_phase      = 1'b0;
      mismatch_count    = 0;
      cycle_count       = 0;
      items_sent        = 0;
      replies_checked   = 0;
      listed_pairs_seen = 0;
      full_errors_seen  = 0;
      shadow_count      = 0;
      for (int i = 0; i < DEPTH; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_low[i]   = '0;
         shadow_high[i]  = '0;
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_ops();
      test_full_table();
      test_random_traffic(20);

      // All requests are in; let the owed replies come back, then watch a
      // quiet stretch for anything extra.
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests and checked %0d result transactions.",
               items_sent, replies_checked);
      $display("Covered %0d listed pairs and %0d full-table rejections.",
               listed_pairs_seen, full_errors_seen);
      if (mismatch_count == 0 && replies_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule : body_pair_exclusion_table_unit_test
